FILE: rtl/frac_pkg.sv
// shared types and codes for the fraction arithmetic reduce block
package frac_pkg;

  // fixed output field widths
  localparam int NUM_BITS = 33;
  localparam int DEN_BITS = 31;
  localparam int OUT_TDATA_W = 64;

  typedef enum logic [1:0] {
    KIND_ADD = 2'd0,
    KIND_SUB = 2'd1,
    KIND_MUL = 2'd2,
    KIND_DIV = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_DIV_ZERO = 2'd1,
    STATUS_DEN_ZERO = 2'd2
  } status_t;

  // top level sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_COMB,
    ST_GCD_GO,
    ST_GCD_WAIT,
    ST_DIVN_GO,
    ST_DIVN_WAIT,
    ST_DIVD_GO,
    ST_DIVD_WAIT,
    ST_DONE
  } state_t;

  // binary gcd sequencer
  typedef enum logic [1:0] {
    GCD_IDLE,
    GCD_STRIP,
    GCD_REDUCE,
    GCD_RESTORE
  } gcd_state_t;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

FILE: rtl/fraction_arithmetic_reduce.sv
// top level: fraction add, subtract, multiply, divide with gcd reduction
//
//  channel | direction | tdata (low bit up)                      | tuser
//  --------+-----------+-----------------------------------------+-------------
//  s_*     | in        | x_num, x_den, y_num, y_den (W bits each) | kind [1:0]
//  m_*     | out       | res_num [32:0], res_den [63:33]          | status [1:0]
//
// one request at a time; the time per request is set by the binary gcd loop (one
// compare/subtract/shift per cycle) and by the two restoring divides
// four magnitude products go through one shared multiplier, one per cycle
// a request with a zero denominator or a divide by zero skips straight to the result
// rst is synchronous and returns the sequencer to idle with no result pending
// a held result on m_* does not block the next request from being taken
module fraction_arithmetic_reduce #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // x_num, x_den, y_num, y_den, zero padding
  input  logic [((4*OPERAND_WIDTH+7)/8)*8-1:0]       s_tdata,
  // kind
  input  logic [1:0]                                 s_tuser,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // res_num, res_den
  output logic [frac_pkg::OUT_TDATA_W-1:0]           m_tdata,
  // status
  output logic [1:0]                                 m_tuser
);

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;
  localparam int NX = (PW > frac_pkg::NUM_BITS) ? PW : frac_pkg::NUM_BITS;
  localparam int DX = (PW > frac_pkg::DEN_BITS) ? PW : frac_pkg::DEN_BITS;

  frac_pkg::state_t state;
  frac_pkg::state_t state_next;

  // input unpacking
  logic [W-1:0] x_num_in, x_den_in, y_num_in, y_den_in;
  logic [W-1:0] xn_mag_in, xd_mag_in, yn_mag_in, yd_mag_in;
  frac_pkg::kind_t   kind_in;
  frac_pkg::status_t status_in;

  assign kind_in  = frac_pkg::kind_t'(s_tuser[1:0]);
  assign x_num_in = s_tdata[0*W +: W];
  assign x_den_in = s_tdata[1*W +: W];
  assign y_num_in = s_tdata[2*W +: W];
  assign y_den_in = s_tdata[3*W +: W];

  // magnitudes; the most negative value maps to 2^(W-1) as unsigned
  assign xn_mag_in = x_num_in[W-1] ? (~x_num_in + 1'b1) : x_num_in;
  assign xd_mag_in = x_den_in[W-1] ? (~x_den_in + 1'b1) : x_den_in;
  assign yn_mag_in = y_num_in[W-1] ? (~y_num_in + 1'b1) : y_num_in;
  assign yd_mag_in = y_den_in[W-1] ? (~y_den_in + 1'b1) : y_den_in;

  // zero denominator check comes ahead of the divide check
  always_comb begin
    if (x_den_in == '0 || y_den_in == '0) begin
      status_in = frac_pkg::STATUS_DEN_ZERO;
    end else if (kind_in == frac_pkg::KIND_DIV && y_num_in == '0) begin
      status_in = frac_pkg::STATUS_DIV_ZERO;
    end else begin
      status_in = frac_pkg::STATUS_OK;
    end
  end

  // request registers
  frac_pkg::kind_t   kind_r;
  frac_pkg::status_t status_r;
  logic [W-1:0] xn_m, xd_m, yn_m, yd_m;
  logic         xn_s, xd_s, yn_s, yd_s;

  // shared multiplier and product registers
  logic [1:0]    step;
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod [4];

  // combine stage
  logic [PW-1:0] sum01, dif10, num_c, den_c;
  logic [PW:0]   dif01;
  logic          s0, s1, ns_c, ds_c;

  logic [PW-1:0] num_mag, den_mag, g_r, qn, qd;
  logic          neg_r;

  // unit interfaces
  logic                 gcd_start, div_start, out_load;
  logic [PW-1:0]        gcd_g, div_quot, div_dividend;
  frac_pkg::unit_stat_t gcd_stat, div_stat;

  // output registers
  logic [frac_pkg::NUM_BITS-1:0] res_num_q;
  logic [frac_pkg::DEN_BITS-1:0] res_den_q;
  frac_pkg::status_t             status_q;
  logic [NX-1:0]                 qn_ext, num_w;
  logic [DX-1:0]                 qd_ext;

  // product order: xn*yd, xd*yn, xd*yd, xn*yn
  always_comb begin
    case (step)
      2'd0:    begin mul_a = xn_m; mul_b = yd_m; end
      2'd1:    begin mul_a = xd_m; mul_b = yn_m; end
      2'd2:    begin mul_a = xd_m; mul_b = yd_m; end
      default: begin mul_a = xn_m; mul_b = yn_m; end
    endcase
  end

  // signed combination of the cross products
  assign s0    = xn_s ^ yd_s;
  assign s1    = xd_s ^ yn_s ^ (kind_r == frac_pkg::KIND_SUB);
  assign sum01 = prod[0] + prod[1];
  assign dif01 = {1'b0, prod[0]} - {1'b0, prod[1]};
  assign dif10 = prod[1] - prod[0];

  always_comb begin
    unique case (kind_r) inside
      frac_pkg::KIND_ADD, frac_pkg::KIND_SUB: begin
        if (s0 == s1) begin
          num_c = sum01;
          ns_c  = s0;
        end else if (!dif01[PW]) begin
          num_c = dif01[PW-1:0];
          ns_c  = s0;
        end else begin
          num_c = dif10;
          ns_c  = s1;
        end
        den_c = prod[2];
        ds_c  = xd_s ^ yd_s;
      end
      frac_pkg::KIND_MUL: begin
        num_c = prod[3];
        ns_c  = xn_s ^ yn_s;
        den_c = prod[2];
        ds_c  = xd_s ^ yd_s;
      end
      default: begin
        num_c = prod[0];
        ns_c  = s0;
        den_c = prod[1];
        ds_c  = xd_s ^ yn_s;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      frac_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (status_in == frac_pkg::STATUS_OK) ? frac_pkg::ST_MUL
                                                          : frac_pkg::ST_DONE;
        end
      end
      frac_pkg::ST_MUL: begin
        if (step == 2'd3) state_next = frac_pkg::ST_COMB;
      end
      frac_pkg::ST_COMB: begin
        state_next = (num_c == '0) ? frac_pkg::ST_DONE : frac_pkg::ST_GCD_GO;
      end
      frac_pkg::ST_GCD_GO:   state_next = frac_pkg::ST_GCD_WAIT;
      frac_pkg::ST_GCD_WAIT: begin
        if (gcd_stat.done) state_next = frac_pkg::ST_DIVN_GO;
      end
      frac_pkg::ST_DIVN_GO:   state_next = frac_pkg::ST_DIVN_WAIT;
      frac_pkg::ST_DIVN_WAIT: begin
        if (div_stat.done) state_next = frac_pkg::ST_DIVD_GO;
      end
      frac_pkg::ST_DIVD_GO:   state_next = frac_pkg::ST_DIVD_WAIT;
      frac_pkg::ST_DIVD_WAIT: begin
        if (div_stat.done) state_next = frac_pkg::ST_DONE;
      end
      frac_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) state_next = frac_pkg::ST_IDLE;
      end
      default: state_next = frac_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready     = (state == frac_pkg::ST_IDLE);
    gcd_start    = (state == frac_pkg::ST_GCD_GO);
    div_start    = (state == frac_pkg::ST_DIVN_GO) || (state == frac_pkg::ST_DIVD_GO);
    div_dividend = (state == frac_pkg::ST_DIVN_GO) ? num_mag : den_mag;
    out_load     = (state == frac_pkg::ST_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= frac_pkg::ST_IDLE;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == frac_pkg::ST_MUL) begin
        step <= step + 2'd1;
      end else begin
        step <= '0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      frac_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          kind_r   <= kind_in;
          status_r <= status_in;
          xn_m <= xn_mag_in;  xn_s <= x_num_in[W-1];
          xd_m <= xd_mag_in;  xd_s <= x_den_in[W-1];
          yn_m <= yn_mag_in;  yn_s <= y_num_in[W-1];
          yd_m <= yd_mag_in;  yd_s <= y_den_in[W-1];
          // special cases report 0/1
          qn <= '0;
          qd <= PW'(1);
        end
      end
      frac_pkg::ST_MUL: begin
        prod[step] <= PW'(mul_a) * PW'(mul_b);
      end
      frac_pkg::ST_COMB: begin
        num_mag <= num_c;
        den_mag <= den_c;
        neg_r   <= ns_c ^ ds_c;
      end
      frac_pkg::ST_GCD_WAIT: begin
        if (gcd_stat.done) g_r <= gcd_g;
      end
      frac_pkg::ST_DIVN_WAIT: begin
        if (div_stat.done) qn <= div_quot;
      end
      frac_pkg::ST_DIVD_WAIT: begin
        if (div_stat.done) qd <= div_quot;
      end
      default: begin
      end
    endcase
  end

  // sign goes on the numerator, both fields wrap to the port widths
  assign qn_ext = NX'(qn);
  assign qd_ext = DX'(qd);
  assign num_w  = neg_r ? (~qn_ext + 1'b1) : qn_ext;

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_num_q <= num_w[frac_pkg::NUM_BITS-1:0];
      res_den_q <= qd_ext[frac_pkg::DEN_BITS-1:0];
      status_q  <= status_r;
    end
  end

  assign m_tdata = {res_den_q, res_num_q};
  assign m_tuser = status_q;

  frac_gcd #(
    .WIDTH (PW)
  ) u_gcd (
    .clk   (clk),
    .rst   (rst),
    .start (gcd_start),
    .a_in  (num_mag),
    .b_in  (den_mag),
    .g     (gcd_g),
    .stat  (gcd_stat)
  );

  frac_div #(
    .WIDTH (PW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (g_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // error results always carry 0/1
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status_q != frac_pkg::STATUS_OK |-> res_num_q == '0 && res_den_q == 1)
    else $error("error result not 0/1");

  // gcd finishes only while the sequencer waits for it
  a_gcd_done: assert property (@(posedge clk) disable iff (rst)
    gcd_stat.done |-> state == frac_pkg::ST_GCD_WAIT)
    else $error("gcd done outside its wait state");

  // divider finishes only while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == frac_pkg::ST_DIVN_WAIT || state == frac_pkg::ST_DIVD_WAIT)
    else $error("divide done outside its wait states");

  // a taken request always blocks the next cycle
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("back to back requests taken");

endmodule

FILE: rtl/frac_div.sv
// iterative restoring divider, one quotient bit per cycle
module frac_div #(
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [WIDTH-1:0]       dividend,
  input  logic [WIDTH-1:0]       divisor,
  output logic [WIDTH-1:0]       quotient,
  output frac_pkg::unit_stat_t   stat
);

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] q;
  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] d;
  logic [CW-1:0]    cnt;
  logic             done;

  logic [WIDTH:0]   sh;
  logic [WIDTH+1:0] dif;
  logic             ge;

  // shift next dividend bit into the partial remainder and trial subtract
  assign sh  = {rem, q[WIDTH-1]};
  assign dif = {1'b0, sh} - {2'b00, d};
  assign ge  = ~dif[WIDTH+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CW'(WIDTH);
      end else if (cnt != '0) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= '0;
      d   <= divisor;
    end else if (cnt != '0) begin
      rem <= ge ? dif[WIDTH-1:0] : sh[WIDTH-1:0];
      q   <= {q[WIDTH-2:0], ge};
    end
  end

  assign quotient  = q;
  assign stat.busy = (cnt != '0);
  assign stat.done = done;

endmodule

FILE: rtl/frac_gcd.sv
// binary gcd unit: one compare, subtract and shift per cycle
module frac_gcd #(
  parameter int WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [WIDTH-1:0]       a_in,
  input  logic [WIDTH-1:0]       b_in,
  output logic [WIDTH-1:0]       g,
  output frac_pkg::unit_stat_t   stat
);

  localparam int KW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  frac_pkg::gcd_state_t state;
  frac_pkg::gcd_state_t state_next;

  logic [WIDTH-1:0] a;
  logic [WIDTH-1:0] b;
  logic [KW-1:0]    k;

  logic [WIDTH:0]   d;
  logic [WIDTH-1:0] d_ba;
  logic             eq;
  logic             a_gt;

  assign d    = {1'b0, a} - {1'b0, b};
  assign d_ba = b - a;
  assign eq   = (d == '0);
  assign a_gt = ~d[WIDTH] & ~eq;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      frac_pkg::GCD_IDLE: begin
        if (start) state_next = frac_pkg::GCD_STRIP;
      end
      frac_pkg::GCD_STRIP: begin
        if (a[0] | b[0]) state_next = frac_pkg::GCD_REDUCE;
      end
      frac_pkg::GCD_REDUCE: begin
        if (eq) state_next = frac_pkg::GCD_RESTORE;
      end
      frac_pkg::GCD_RESTORE: begin
        if (k == '0) state_next = frac_pkg::GCD_IDLE;
      end
      default: state_next = frac_pkg::GCD_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    stat.busy = (state != frac_pkg::GCD_IDLE);
    stat.done = (state == frac_pkg::GCD_RESTORE) && (k == '0);
    g         = a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= frac_pkg::GCD_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == frac_pkg::GCD_IDLE && start) begin
        k <= '0;
      end else if (state == frac_pkg::GCD_STRIP && !(a[0] | b[0])) begin
        k <= k + KW'(1);
      end else if (state == frac_pkg::GCD_RESTORE && k != '0) begin
        k <= k - KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      frac_pkg::GCD_IDLE: begin
        if (start) begin
          a <= a_in;
          b <= b_in;
        end
      end
      frac_pkg::GCD_STRIP: begin
        // strip common factors of two
        if (!(a[0] | b[0])) begin
          a <= a >> 1;
          b <= b >> 1;
        end
      end
      frac_pkg::GCD_REDUCE: begin
        if (!eq) begin
          if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a_gt) begin
            a <= d[WIDTH-1:0] >> 1;
          end else begin
            b <= d_ba >> 1;
          end
        end
      end
      frac_pkg::GCD_RESTORE: begin
        // put the common factors of two back
        if (k != '0) a <= a << 1;
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: tb/fraction_arithmetic_reduce_test.sv
// testbench for fraction_arithmetic_reduce: directed table plus random requests, scoreboard
`timescale 1ns / 100ps

module fraction_arithmetic_reduce_test;

  localparam int OPW = 16;
  localparam int IN_TDATA_W = ((4 * OPW + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;   // cycles with no handshake on either side
  localparam int RANDOM_PER_PHASE = 200;
  localparam int DRAIN_CYCLES = 400;   // worst case request latency with margin

  // one request as the sender sees it
  typedef struct packed {
    frac_pkg::kind_t kind;
    logic [OPW-1:0] x_num;
    logic [OPW-1:0] x_den;
    logic [OPW-1:0] y_num;
    logic [OPW-1:0] y_den;
  } frac_req_t;

  // one reduced fraction as it leaves the block
  typedef struct packed {
    logic [frac_pkg::NUM_BITS-1:0] res_num;
    logic [frac_pkg::DEN_BITS-1:0] res_den;
    frac_pkg::status_t status;
  } frac_result_t;

  // directed stimulus; typed rows carry the answer, the rest go through the predictor
  typedef struct packed {
    frac_req_t req;
    bit typed;
    frac_result_t want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [frac_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [1:0] m_tuser;

  frac_result_t reduced_q[$];   // expected results, oldest first
  directed_row_t directed_rows[$];
  int send_idle_pct = 17;
  int recv_idle_pct = 70;
  int mismatches = 0;
  int idle_cycles = 0;

  fraction_arithmetic_reduce #(
    .OPERAND_WIDTH(OPW)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    mismatches++;
  endtask

  // exact rational result: cross products in 64 bits, euclid on the magnitudes,
  // sign carried by the numerator, then wrapped to the output field widths
  function automatic frac_result_t reduce_fraction(input frac_req_t req);
    longint xn, xd, yn, yd, num, den, p, q, t, reduced;
    frac_result_t res;
    bit neg;
    xn = $signed(req.x_num);
    xd = $signed(req.x_den);
    yn = $signed(req.y_num);
    yd = $signed(req.y_den);
    res.res_num = '0;
    res.res_den = frac_pkg::DEN_BITS'(1);
    res.status = frac_pkg::STATUS_OK;
    // zero denominator wins over divide by zero
    if (xd == 0 || yd == 0) begin
      res.status = frac_pkg::STATUS_DEN_ZERO;
      return res;
    end
    if (req.kind == frac_pkg::KIND_DIV && yn == 0) begin
      res.status = frac_pkg::STATUS_DIV_ZERO;
      return res;
    end
    case (req.kind)
      frac_pkg::KIND_ADD: begin
        num = xn * yd + xd * yn;
        den = xd * yd;
      end
      frac_pkg::KIND_SUB: begin
        num = xn * yd - xd * yn;
        den = xd * yd;
      end
      frac_pkg::KIND_MUL: begin
        num = xn * yn;
        den = xd * yd;
      end
      default: begin
        num = xn * yd;
        den = xd * yn;
      end
    endcase
    // zero numerator reads as 0/1
    if (num == 0) begin
      return res;
    end
    neg = (num < 0) != (den < 0);
    num = (num < 0) ? -num : num;
    den = (den < 0) ? -den : den;
    p = num;
    q = den;
    while (q != 0) begin
      t = p % q;
      p = q;
      q = t;
    end
    reduced = neg ? -(num / p) : (num / p);
    res.res_num = reduced[frac_pkg::NUM_BITS-1:0];
    reduced = den / p;
    res.res_den = reduced[frac_pkg::DEN_BITS-1:0];
    return res;
  endfunction

  // operand mix: full range, small values near zero, extremes, and values
  // with small common factors so the gcd step has something to remove
  function automatic logic [OPW-1:0] pick_operand();
    logic [OPW-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = OPW'($urandom);
      4, 5, 6: v = OPW'($urandom_range(40)) - OPW'(20);
      7: begin
        case ($urandom_range(4))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'hffff;
          3: v = 16'h0001;
          default: v = 16'h8001;
        endcase
      end
      default: begin
        v = OPW'($urandom_range(1, 12) * $urandom_range(1, 2700));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic frac_req_t random_request();
    frac_req_t req;
    int sel;
    req.kind = frac_pkg::kind_t'($urandom_range(3));
    req.x_num = pick_operand();
    req.y_num = pick_operand();
    do req.x_den = pick_operand(); while (req.x_den == '0);
    do req.y_den = pick_operand(); while (req.y_den == '0);
    // a minority of malformed requests: zero denominators, divide by zero
    sel = $urandom_range(99);
    if (sel < 4) begin
      req.x_den = '0;
    end else if (sel < 8) begin
      req.y_den = '0;
    end else if (sel < 13) begin
      req.kind = frac_pkg::KIND_DIV;
      req.y_num = '0;
    end
    return req;
  endfunction

  // present one request, hold it until taken, then log what must come back
  task automatic send_request(input frac_req_t req, input bit typed,
                              input frac_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {req.y_den, req.y_num, req.x_den, req.x_num};
    s_tuser <= req.kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    reduced_q.push_back(typed ? want : reduce_fraction(req));
  endtask

  // sender pauses until every outstanding result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk);
  endtask

  // result side: random backpressure, compare each taken result with the oldest expectation
  always @(posedge clk) begin
    frac_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_tvalid && m_tready) begin
        if (reduced_q.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = reduced_q.pop_front();
          if (m_tdata[frac_pkg::NUM_BITS-1:0] !== want.res_num) begin
            report_mismatch($sformatf("res_num got %0d want %0d",
              $signed(m_tdata[frac_pkg::NUM_BITS-1:0]), $signed(want.res_num)));
          end
          if (m_tdata[frac_pkg::NUM_BITS+frac_pkg::DEN_BITS-1:frac_pkg::NUM_BITS]
              !== want.res_den) begin
            report_mismatch($sformatf("res_den got %0d want %0d",
              m_tdata[frac_pkg::NUM_BITS+frac_pkg::DEN_BITS-1:frac_pkg::NUM_BITS],
              want.res_den));
          end
          if (m_tuser !== want.status) begin
            report_mismatch($sformatf("status got %0d want %0d", m_tuser, want.status));
          end
        end
      end
    end
  end

  // watchdog: too long with nothing moving on either channel means a hang
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("fraction_arithmetic_reduce: mismatch");
      $finish;
    end
  end

  initial begin
    directed_rows = '{
      // plain add, through the predictor
      '{'{frac_pkg::KIND_ADD, 16'sd1, 16'sd2, 16'sd1, 16'sd3}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      // zero input denominators, either side, on add and subtract
      '{'{frac_pkg::KIND_ADD, 16'sd5, 16'sd0, 16'sd1, 16'sd3}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_DEN_ZERO}},
      '{'{frac_pkg::KIND_SUB, 16'sd1, 16'sd2, 16'sd7, 16'sd0}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_DEN_ZERO}},
      // zero denominator takes priority over divide by a zero fraction
      '{'{frac_pkg::KIND_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd0}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_DEN_ZERO}},
      // divide by a zero fraction
      '{'{frac_pkg::KIND_DIV, 16'sd3, 16'sd4, 16'sd0, 16'sd5}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_DIV_ZERO}},
      '{'{frac_pkg::KIND_DIV, 16'sd3, 16'sd4, 16'sd0, -16'sd32768}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_DIV_ZERO}},
      // zero numerator, directly and by cancellation
      '{'{frac_pkg::KIND_MUL, 16'sd0, 16'sd5, 16'sd3, 16'sd7}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_ADD, 16'sd5, 16'sd7, -16'sd5, 16'sd7}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_SUB, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768}, 1'b1,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      // extremes of the operand range
      '{'{frac_pkg::KIND_MUL, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1}, 1'b1,
        '{33'sd1073741824, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_ADD, -16'sd32768, 16'sd1, -16'sd32768, 16'sd1}, 1'b1,
        '{-33'sd65536, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_SUB, 16'sd32767, 16'sd1, -16'sd32768, 16'sd1}, 1'b1,
        '{33'sd65535, 31'd1, frac_pkg::STATUS_OK}},
      // sign moves to the numerator
      '{'{frac_pkg::KIND_DIV, 16'sd1, 16'sd1, -16'sd32768, 16'sd1}, 1'b1,
        '{-33'sd1, 31'd32768, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_MUL, 16'sd3, -16'sd4, 16'sd5, 16'sd6}, 1'b1,
        '{-33'sd5, 31'd8, frac_pkg::STATUS_OK}},
      // the rest through the predictor
      '{'{frac_pkg::KIND_ADD, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_SUB, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_DIV, -16'sd32768, 16'sd32767, 16'sd1, -16'sd32768}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_SUB, 16'sd7, 16'sd12, 16'sd5, 16'sd18}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_DIV, -16'sd9, 16'sd10, 16'sd3, -16'sd25}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_ADD, 16'sd32767, 16'sd32766, 16'sd1, 16'sd32765}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_MUL, 16'sd32767, -16'sd1, 16'sd32767, -16'sd1}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}},
      '{'{frac_pkg::KIND_ADD, -16'sd1, -16'sd1, -16'sd1, -16'sd1}, 1'b0,
        '{'0, 31'd1, frac_pkg::STATUS_OK}}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // random part: slow receiver, then slow sender, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 70 : 0;
      recv_idle_pct = (phase == 0) ? 70 : (phase == 1) ? 17 : 0;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        send_request(random_request(), 1'b0, '0);
      end
      drain_results();
    end

    // let any late or stray result show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && reduced_q.size() == 0) begin
      $display("fraction_arithmetic_reduce: match");
    end else begin
      $display("fraction_arithmetic_reduce: mismatch");
    end
    $finish;
  end

endmodule
